/* rtl/ctt_pkg.sv */
package ctt_pkg;

  localparam int LEN_W  = 7;
  localparam int ADDR_W = 6;

  localparam logic [7:0] CH_END   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  localparam logic [1:0] ST_TOKEN = 2'd0;
  localparam logic [1:0] ST_BREAK = 2'd1;
  localparam logic [1:0] ST_END   = 2'd2;
  localparam logic [1:0] ST_OVER  = 2'd3;

  typedef enum logic [3:0] {
    PH_NEW, PH_SKIP, PH_SLASH, PH_LCOM, PH_BCOM, PH_BSTAR,
    PH_STR, PH_EOL, PH_EOL_SLASH, PH_PLAIN
  } phase_t;

  typedef enum logic [1:0] {
    BK_IDLE, BK_READ, BK_DATA, BK_HOLD
  } bstate_t;

  // One entry of the command queue: either a whole stored token or a single
  // empty result that carries only a status.
  typedef struct packed {
    logic             is_tok;
    logic [LEN_W-1:0] len;
    logic [1:0]       status;
  } cmd_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } wr_t;

endpackage

/* rtl/ctt_front.sv */
module ctt_front #(
  parameter int TOKEN_MAX = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [7:0]    char_code,
  input  logic          allow_line_breaks,
  input  logic          until_eol,
  input  logic          in_valid,
  output logic          in_ready,
  output ctt_pkg::cmd_t push_cmd,
  output logic          push,
  input  logic          full,
  output ctt_pkg::wr_t  wr,
  input  logic          tok_done
);
  import ctt_pkg::*;

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(TOKEN_MAX);

  logic             cur_v;
  logic [7:0]       c;
  logic             al;
  logic             eo;
  phase_t           phase, phase_next, ph;
  logic [1:0]       lat, lat_next;
  logic             saw, saw_next;
  logic [LEN_W-1:0] len, len_next;
  logic [LEN_W-1:0] keep, keep_next;
  logic             ended, ended_next;
  logic             pending;

  logic             again, app, fin, trim, et, stall, step, req_push;
  logic [7:0]       app_d;
  logic [LEN_W-1:0] flen;
  cmd_t             cmd;

  assign in_ready = !cur_v;

  always_comb begin
    ph = phase;
    lat_next = lat;
    saw_next = saw;
    len_next = len;
    keep_next = keep;
    ended_next = ended;
    again = 1'b0;
    app = 1'b0;
    app_d = c;
    fin = 1'b0;
    trim = 1'b0;
    et = 1'b0;
    req_push = 1'b0;
    cmd = '0;
    flen = '0;
    if (phase == PH_NEW) begin
      lat_next = {eo, al};
      saw_next = 1'b0;
      len_next = '0;
      keep_next = '0;
      ph = PH_SKIP;
    end
    phase_next = ph;
    case (ph)
      PH_SKIP: begin
        if (c == CH_END) begin
          et = 1'b1;
        end else if (c <= CH_SPACE) begin
          if (c == CH_LF) saw_next = 1'b1;
        end else if (saw_next && !lat_next[0]) begin
          req_push = 1'b1;
          cmd = '{is_tok: 1'b0, len: '0, status: ST_BREAK};
          phase_next = PH_NEW;
          again = 1'b1;
        end else if (c == CH_SLASH) begin
          phase_next = PH_SLASH;
        end else begin
          len_next = '0;
          keep_next = '0;
          if (c == CH_QUOTE) begin
            phase_next = PH_STR;
          end else begin
            phase_next = lat_next[1] ? PH_EOL : PH_PLAIN;
            again = 1'b1;
          end
        end
      end
      PH_SLASH: begin
        if (c == CH_SLASH) begin
          phase_next = PH_LCOM;
        end else if (c == CH_STAR) begin
          phase_next = PH_BCOM;
        end else begin
          len_next = '0;
          keep_next = '0;
          app = 1'b1;
          app_d = CH_SLASH;
          phase_next = lat_next[1] ? PH_EOL : PH_PLAIN;
          again = 1'b1;
        end
      end
      PH_LCOM: begin
        if (c == CH_END) begin
          et = 1'b1;
        end else if (c == CH_LF) begin
          saw_next = 1'b1;
          phase_next = PH_SKIP;
        end
      end
      PH_BCOM: begin
        if (c == CH_END) et = 1'b1;
        else if (c == CH_STAR) phase_next = PH_BSTAR;
      end
      PH_BSTAR: begin
        if (c == CH_END) begin
          et = 1'b1;
        end else if (c == CH_SLASH) begin
          saw_next = 1'b0;
          phase_next = PH_SKIP;
        end else if (c != CH_STAR) begin
          phase_next = PH_BCOM;
        end
      end
      PH_STR: begin
        if (c == CH_QUOTE) begin
          fin = 1'b1;
          phase_next = PH_NEW;
        end else if (c == CH_END) begin
          fin = 1'b1;
          phase_next = PH_NEW;
          again = 1'b1;
        end else begin
          app = 1'b1;
        end
      end
      PH_EOL: begin
        if (c == CH_END || c == CH_LF || c == CH_CR) begin
          fin = 1'b1;
          trim = 1'b1;
          phase_next = PH_NEW;
          again = 1'b1;
        end else if (c == CH_SLASH) begin
          phase_next = PH_EOL_SLASH;
        end else begin
          app = 1'b1;
        end
      end
      PH_EOL_SLASH: begin
        if (c == CH_SLASH || c == CH_STAR) begin
          fin = 1'b1;
          trim = 1'b1;
          lat_next = {eo, al};
          saw_next = 1'b0;
          phase_next = (c == CH_SLASH) ? PH_LCOM : PH_BCOM;
        end else begin
          app = 1'b1;
          app_d = CH_SLASH;
          phase_next = PH_EOL;
          again = 1'b1;
        end
      end
      PH_PLAIN: begin
        if (c > CH_SPACE) begin
          app = 1'b1;
        end else begin
          fin = 1'b1;
          phase_next = PH_NEW;
          again = 1'b1;
        end
      end
      default: begin
        phase_next = PH_NEW;
        again = 1'b1;
      end
    endcase

    // Trimming keeps the stored length up to the last byte at or above space.
    if (fin) begin
      flen = trim ? keep_next : len_next;
      req_push = 1'b1;
      if (flen >= MAX_LEN) cmd = '{is_tok: 1'b0, len: '0, status: ST_OVER};
      else if (flen == '0) cmd = '{is_tok: 1'b0, len: '0, status: ST_TOKEN};
      else cmd = '{is_tok: 1'b1, len: flen, status: ST_TOKEN};
      len_next = '0;
      keep_next = '0;
    end
    if (et) begin
      req_push = 1'b1;
      cmd = '{is_tok: 1'b0, len: '0, status: ST_END};
      ended_next = 1'b1;
      phase_next = PH_NEW;
    end

    wr = '{en: 1'b0, addr: ADDR_W'(len_next), data: app_d};
    if (app && len_next < MAX_LEN) begin
      wr.en = 1'b1;
      if (app_d >= CH_SPACE) keep_next = len_next + LEN_W'(1);
      len_next = len_next + LEN_W'(1);
    end

    // The token store holds one token, so appends wait until it is drained.
    stall = (req_push && full) || (app && pending);
    step = cur_v && !stall;
    push = step && req_push;
    push_cmd = cmd;
    wr.en = wr.en && step;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_v <= 1'b0;
      phase <= PH_NEW;
      lat <= '0;
      saw <= 1'b0;
      len <= '0;
      keep <= '0;
      ended <= 1'b0;
      pending <= 1'b0;
    end else begin
      if (!cur_v) begin
        if (in_valid && !ended) begin
          cur_v <= 1'b1;
          c <= char_code;
          al <= allow_line_breaks;
          eo <= until_eol;
        end
      end else if (step) begin
        phase <= phase_next;
        lat <= lat_next;
        saw <= saw_next;
        len <= len_next;
        keep <= keep_next;
        ended <= ended_next;
        cur_v <= again && !ended_next;
      end
      if (push && cmd.is_tok) pending <= 1'b1;
      else if (tok_done) pending <= 1'b0;
    end
  end

endmodule

/* rtl/ctt_fifo.sv */
module ctt_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ctt_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output ctt_pkg::cmd_t pop_cmd,
  output logic          empty
);
  import ctt_pkg::*;

  cmd_t       q [4];
  logic [1:0] wp, rp;
  logic [2:0] cnt;

  assign full = (cnt == 3'd4);
  assign empty = (cnt == 3'd0);
  assign pop_cmd = q[rp];

  always_ff @(posedge clk) begin
    if (push) q[wp] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 2'd1;
      if (pop) rp <= rp + 2'd1;
      cnt <= cnt + 3'(push) - 3'(pop);
    end
  end

endmodule

/* rtl/ctt_back.sv */
module ctt_back #(
  parameter int TOKEN_MAX = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  ctt_pkg::wr_t  wr,
  input  logic          empty,
  input  ctt_pkg::cmd_t pop_cmd,
  output logic          pop,
  output logic          tok_done,
  output logic [7:0]    token_byte,
  output logic          byte_valid,
  output logic          last,
  output logic [1:0]    status,
  output logic          out_valid,
  input  logic          out_ready
);
  import ctt_pkg::*;

  localparam int AW = (TOKEN_MAX > 1) ? $clog2(TOKEN_MAX) : 1;

  logic [7:0]       mem [TOKEN_MAX];
  logic [7:0]       rdata;
  bstate_t          state, state_next;
  cmd_t             cur;
  logic [LEN_W-1:0] idx;
  logic             load_single, load_byte, adv;

  always_ff @(posedge clk) begin
    if (wr.en) mem[wr.addr[AW-1:0]] <= wr.data;
    rdata <= mem[idx[AW-1:0]];
  end

  always_comb begin
    state_next = state;
    pop = 1'b0;
    load_single = 1'b0;
    load_byte = 1'b0;
    adv = 1'b0;
    tok_done = 1'b0;
    case (state)
      BK_IDLE: begin
        if (!empty) begin
          pop = 1'b1;
          if (pop_cmd.is_tok) begin
            state_next = BK_READ;
          end else begin
            load_single = 1'b1;
            state_next = BK_HOLD;
          end
        end
      end
      BK_READ: state_next = BK_DATA;
      BK_DATA: begin
        load_byte = 1'b1;
        state_next = BK_HOLD;
      end
      BK_HOLD: begin
        if (out_ready) begin
          if (cur.is_tok && !last) begin
            adv = 1'b1;
            state_next = BK_READ;
          end else begin
            tok_done = cur.is_tok;
            state_next = BK_IDLE;
          end
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  assign out_valid = (state == BK_HOLD);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= pop_cmd;
      idx <= '0;
    end else if (adv) begin
      idx <= idx + LEN_W'(1);
    end
    if (load_single) begin
      token_byte <= '0;
      byte_valid <= 1'b0;
      last <= 1'b1;
      status <= pop_cmd.status;
    end else if (load_byte) begin
      token_byte <= rdata;
      byte_valid <= 1'b1;
      last <= (idx + LEN_W'(1) == cur.len);
      status <= ST_TOKEN;
    end
  end

endmodule

/* rtl/config_text_tokenizer.sv */
// Byte-serial tokenizer: each accepted text byte is captured, then scanned, and a
// byte that starts an unquoted token, ends a token or ends a line-break search is
// scanned again, once per rescan. Tokens are stored in a TOKEN_MAX-byte buffer and
// drained by the emitter one output byte at a time (memory read, output load,
// handshake), after each command is taken from the queue; an empty result is loaded
// from the queue straight into the handshake state, with no memory read.
// The scanner stalls on its next stored byte until the previous token is drained.
// A four-entry command queue lets skipping and comments run while results drain.
module config_text_tokenizer #(
  parameter int TOKEN_MAX = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] char_code,
  input  logic       allow_line_breaks,
  input  logic       until_eol,
  input  logic       in_valid,
  output logic       in_ready,
  output logic [7:0] token_byte,
  output logic       byte_valid,
  output logic       last,
  output logic [1:0] status,
  output logic       out_valid,
  input  logic       out_ready
);
  import ctt_pkg::*;

  cmd_t push_cmd, pop_cmd;
  wr_t  wr;
  logic push, full, pop, empty, tok_done;

  ctt_front #(.TOKEN_MAX(TOKEN_MAX)) u_front (
    .clk(clk), .rst(rst),
    .char_code(char_code), .allow_line_breaks(allow_line_breaks),
    .until_eol(until_eol), .in_valid(in_valid), .in_ready(in_ready),
    .push_cmd(push_cmd), .push(push), .full(full), .wr(wr), .tok_done(tok_done)
  );

  ctt_fifo u_fifo (
    .clk(clk), .rst(rst),
    .push(push), .push_cmd(push_cmd), .full(full),
    .pop(pop), .pop_cmd(pop_cmd), .empty(empty)
  );

  ctt_back #(.TOKEN_MAX(TOKEN_MAX)) u_back (
    .clk(clk), .rst(rst), .wr(wr),
    .empty(empty), .pop_cmd(pop_cmd), .pop(pop), .tok_done(tok_done),
    .token_byte(token_byte), .byte_valid(byte_valid), .last(last),
    .status(status), .out_valid(out_valid), .out_ready(out_ready)
  );

endmodule

/* test/config_text_tokenizer_tb.sv */
module config_text_tokenizer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ctt_pkg::*;

  localparam int TOK_MAX     = 64;
  localparam int CYCLE_LIMIT = 300000;

  typedef struct {
    logic [7:0] ch;
    logic       allow;
    logic       eol;
  } text_byte_t;

  typedef struct {
    logic [7:0] tok_byte;
    logic       valid;
    logic       last;
    logic [1:0] status;
  } token_result_t;

  // Tracks the tokenizer state on every accepted text byte and keeps the
  // results that are still owed by the block.
  class tokenizer_scoreboard;
    phase_t          phase;
    logic [7:0]      store[TOK_MAX];
    int unsigned     tok_len;
    bit              nl_seen;
    bit [1:0]        mode;
    bit              ended;
    token_result_t   pending[$];
    int              errors;

    function new();
      phase = PH_NEW;
      tok_len = 0;
      nl_seen = 0;
      mode = 0;
      ended = 0;
      errors = 0;
    endfunction

    task report(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function void owe(input logic [7:0] b, input logic v, input logic l, input logic [1:0] s);
      token_result_t r;
      r.tok_byte = b;
      r.valid = v;
      r.last = l;
      r.status = s;
      pending.push_back(r);
    endfunction

    function void put_byte(input logic [7:0] c);
      if (tok_len < TOK_MAX) begin
        store[tok_len] = c;
        tok_len++;
      end
    endfunction

    function void close_token(input bit trim);
      int unsigned i;
      if (trim)
        while (tok_len > 0 && store[tok_len-1] < CH_SPACE) tok_len--;
      if (tok_len >= TOK_MAX) owe(8'h00, 0, 1, ST_OVER);
      else if (tok_len == 0) owe(8'h00, 0, 1, ST_TOKEN);
      else
        for (i = 0; i < tok_len; i++) owe(store[i], 1, i + 1 == tok_len, ST_TOKEN);
      tok_len = 0;
      phase = PH_NEW;
    endfunction

    function void close_text();
      owe(8'h00, 0, 1, ST_END);
      ended = 1;
      phase = PH_NEW;
    endfunction

    function bit line_byte(input logic [7:0] c);
      if (c == CH_END || c == CH_LF || c == CH_CR) begin
        close_token(1);
        return 1;
      end
      if (c == CH_SLASH) begin
        phase = PH_EOL_SLASH;
        return 0;
      end
      put_byte(c);
      return 0;
    endfunction

    function bit word_byte(input logic [7:0] c);
      if (c > CH_SPACE) begin
        put_byte(c);
        return 0;
      end
      close_token(0);
      return 1;
    endfunction

    // Returns 1 when the byte has to be scanned again as the start of a new search.
    function bit scan(input logic [7:0] c, input logic a, input logic e);
      case (phase)
        PH_NEW, PH_SKIP: begin
          if (phase == PH_NEW) begin
            mode = {e, a};
            nl_seen = 0;
            tok_len = 0;
            phase = PH_SKIP;
          end
          if (c == CH_END) begin
            close_text();
            return 0;
          end
          if (c <= CH_SPACE) begin
            if (c == CH_LF) nl_seen = 1;
            return 0;
          end
          if (nl_seen && !mode[0]) begin
            owe(8'h00, 0, 1, ST_BREAK);
            phase = PH_NEW;
            return 1;
          end
          if (c == CH_SLASH) begin
            phase = PH_SLASH;
            return 0;
          end
          tok_len = 0;
          if (c == CH_QUOTE) begin
            phase = PH_STR;
            return 0;
          end
          if (mode[1]) begin
            phase = PH_EOL;
            return line_byte(c);
          end
          phase = PH_PLAIN;
          return word_byte(c);
        end
        PH_SLASH: begin
          if (c == CH_SLASH) begin
            phase = PH_LCOM;
            return 0;
          end
          if (c == CH_STAR) begin
            phase = PH_BCOM;
            return 0;
          end
          tok_len = 0;
          put_byte(CH_SLASH);
          if (mode[1]) begin
            phase = PH_EOL;
            return line_byte(c);
          end
          phase = PH_PLAIN;
          return word_byte(c);
        end
        PH_LCOM: begin
          if (c == CH_END) begin
            close_text();
            return 0;
          end
          if (c == CH_LF) begin
            nl_seen = 1;
            phase = PH_SKIP;
          end
          return 0;
        end
        PH_BCOM: begin
          if (c == CH_END) begin
            close_text();
            return 0;
          end
          if (c == CH_STAR) phase = PH_BSTAR;
          return 0;
        end
        PH_BSTAR: begin
          if (c == CH_END) begin
            close_text();
            return 0;
          end
          if (c == CH_SLASH) begin
            nl_seen = 0;
            phase = PH_SKIP;
          end else if (c != CH_STAR) begin
            phase = PH_BCOM;
          end
          return 0;
        end
        PH_STR: begin
          if (c == CH_QUOTE) begin
            close_token(0);
            return 0;
          end
          if (c == CH_END) begin
            close_token(0);
            return 1;
          end
          put_byte(c);
          return 0;
        end
        PH_EOL: return line_byte(c);
        PH_EOL_SLASH: begin
          if (c == CH_SLASH || c == CH_STAR) begin
            close_token(1);
            mode = {e, a};
            nl_seen = 0;
            tok_len = 0;
            phase = (c == CH_SLASH) ? PH_LCOM : PH_BCOM;
            return 0;
          end
          put_byte(CH_SLASH);
          phase = PH_EOL;
          return line_byte(c);
        end
        PH_PLAIN: return word_byte(c);
        default: begin
          phase = PH_NEW;
          return 1;
        end
      endcase
    endfunction

    function void note_input(input logic [7:0] c, input logic a, input logic e);
      int pass;
      if (ended) return;
      for (pass = 0; pass < 4; pass++) begin
        if (!scan(c, a, e)) break;
        if (ended) break;
      end
    endfunction

    task check_result(input logic [7:0] b, input logic v, input logic l, input logic [1:0] s);
      token_result_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result byte=%h valid=%b last=%b status=%0d", b, v, l, s));
        return;
      end
      want = pending.pop_front();
      if (b !== want.tok_byte)
        report($sformatf("token_byte %h, want %h", b, want.tok_byte));
      if (v !== want.valid)
        report($sformatf("byte_valid %b, want %b", v, want.valid));
      if (l !== want.last)
        report($sformatf("last %b, want %b", l, want.last));
      if (s !== want.status)
        report($sformatf("status %0d, want %0d", s, want.status));
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic [7:0] char_code = 8'h00;
  logic       allow_line_breaks = 1'b0;
  logic       until_eol = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] token_byte;
  logic       byte_valid;
  logic       last;
  logic [1:0] status;
  logic       out_valid;
  logic       out_ready = 1'b0;

  tokenizer_scoreboard sb = new();
  text_byte_t          text_q[$];
  int                  sent_count = 0;
  int                  cycles = 0;
  bit                  quiet = 0;

  config_text_tokenizer u_top (
    .clk              (clk),
    .rst              (rst),
    .char_code        (char_code),
    .allow_line_breaks(allow_line_breaks),
    .until_eol        (until_eol),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .token_byte       (token_byte),
    .byte_valid       (byte_valid),
    .last             (last),
    .status           (status),
    .out_valid        (out_valid),
    .out_ready        (out_ready)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result(token_byte, byte_valid, last, status);
  end

  function automatic void add_byte(input logic [7:0] c, input logic a, input logic e);
    text_byte_t t;
    t.ch = c;
    t.allow = a;
    t.eol = e;
    text_q.push_back(t);
  endfunction

  function automatic void add_str(input string s, input logic a, input logic e);
    int i;
    for (i = 0; i < s.len(); i++) add_byte(s[i], a, e);
  endfunction

  function automatic void add_word(input int n, input logic a, input logic e);
    int i;
    for (i = 0; i < n; i++) add_byte(8'($urandom_range(8'h21, 8'hFF)), a, e);
  endfunction

  // Bytes that are neither end of text nor above space.
  function automatic logic [7:0] blank_byte();
    case ($urandom_range(0, 3))
      0: return CH_SPACE;
      1: return 8'h09;
      default: return 8'($urandom_range(1, 8'h1F));
    endcase
  endfunction

  function automatic void add_fragment();
    logic a;
    logic e;
    int   i;
    int   kind;
    a = 1'($urandom_range(0, 1));
    e = ($urandom_range(0, 2) == 0);
    kind = $urandom_range(0, 11);
    case (kind)
      0: add_word($urandom_range(1, 8), a, e);
      1: for (i = $urandom_range(1, 3); i > 0; i--) add_byte(blank_byte(), a, e);
      2: add_byte(CH_LF, a, e);
      3: add_str("\r\n", a, e);
      4: begin
        add_str("//", a, e);
        add_word($urandom_range(0, 5), a, e);
        add_byte(CH_LF, a, e);
      end
      5: begin
        add_str("/*", a, e);
        for (i = $urandom_range(0, 6); i > 0; i--)
          add_byte($urandom_range(0, 2) == 0 ? CH_STAR : 8'($urandom_range(1, 8'hFF)), a, e);
        add_str("*/", a, e);
      end
      6: begin
        add_byte(CH_QUOTE, a, e);
        for (i = $urandom_range(0, 6); i > 0; i--) begin
          logic [7:0] c;
          c = 8'($urandom_range(1, 8'hFF));
          add_byte(c == CH_QUOTE ? CH_SPACE : c, a, e);
        end
        add_byte(CH_QUOTE, a, e);
      end
      7: begin
        add_byte(CH_SLASH, a, e);
        add_word($urandom_range(0, 4), a, e);
      end
      8: begin
        // Rest-of-line text with embedded blanks and trailing control bytes.
        add_word($urandom_range(1, 4), a, 1);
        add_byte(blank_byte(), a, 1);
        add_byte(CH_SLASH, a, 1);
        add_word($urandom_range(0, 3), a, 1);
        for (i = $urandom_range(0, 3); i > 0; i--)
          add_byte(8'($urandom_range(1, 8'h1F)), a, 1);
        add_byte($urandom_range(0, 1) ? CH_LF : CH_CR, a, 1);
      end
      9: begin
        if ($urandom_range(0, 4) == 0) begin
          if ($urandom_range(0, 1)) begin
            add_word($urandom_range(TOK_MAX - 4, TOK_MAX + 6), a, e);
            add_byte(CH_SPACE, a, e);
          end else begin
            add_byte(CH_QUOTE, a, 0);
            add_word($urandom_range(TOK_MAX - 2, TOK_MAX + 4), a, 0);
            add_byte(CH_QUOTE, a, 0);
          end
        end else begin
          add_word(3, a, e);
        end
      end
      10: begin
        if ($urandom_range(0, 1)) add_str("*/", a, e);
        else add_str("**/", a, e);
      end
      default: begin
        add_word($urandom_range(1, 3), a, 1);
        add_str($urandom_range(0, 1) ? "//" : "/*", a, e);
        add_word(2, a, e);
        add_str(" */\n", a, e);
      end
    endcase
  endfunction

  task send_byte(input text_byte_t t);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1'b1;
    char_code <= t.ch;
    allow_line_breaks <= t.allow;
    until_eol <= t.eol;
    do @(posedge clk); while (!in_ready);
    sb.note_input(t.ch, t.allow, t.eol);
    sent_count++;
  endtask

  // Result side: random stall bursts, plus one long hold-off while text keeps coming.
  initial begin
    bit long_done;
    int k;
    long_done = 0;
    wait (!rst);
    forever begin
      if (!long_done && sent_count >= 120) begin
        out_ready <= 1'b0;
        for (k = 0; k < 400; k++) @(posedge clk);
        long_done = 1;
      end else if (!quiet && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  initial begin
    int i;
    int quiet_at;
    // Short directed text: plain words, an empty string, a lone slash, a block
    // comment, a refused line break, rest-of-line tokens with trimming and a
    // comment start that ends such a token.
    add_str("ab \"\" /x ", 1, 0);
    add_str("/**/\nq ", 0, 0);
    add_str("k\t/z\r", 1, 1);
    add_str("m\t\001\n", 1, 1);
    add_str("c//x\n", 1, 1);
    while (text_q.size() < 430) add_fragment();
    // A string cut off by end of text, then bytes that must be ignored.
    add_str("\"tail", 1, 0);
    add_byte(CH_END, 1, 0);
    add_str("zz ", 1, 0);
    quiet_at = (text_q.size() * 85) / 100;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (i = 0; i < text_q.size(); i++) begin
      if (i >= quiet_at) quiet = 1;
      send_byte(text_q[i]);
    end
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
